[hdl/npc_pkg.sv]
// Shared types, constants and a helper function for the nearest palette colour quantiser.
`timescale 1ns / 1ps
`default_nettype none
package npc_pkg;

   localparam int IDX_W   = 8;
   localparam int CHAN_W  = 8;
   localparam int COLOR_W = 3 * CHAN_W;
   localparam int DIST_W  = 10;

   localparam int PALETTE_SIZE_DEFAULT = 256;

   // Largest distance a real comparison can give is three times a full channel swing.
   localparam logic [DIST_W-1:0] DIST_LIMIT = DIST_W'(3 * ((1 << CHAN_W) - 1));
   // Starting distance that any palette entry beats.
   localparam logic [DIST_W-1:0] DIST_START = {DIST_W{1'b1}};

   localparam int RED_LSB   = 2 * CHAN_W;
   localparam int GREEN_LSB = CHAN_W;
   localparam int BLUE_LSB  = 0;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_PIXEL = 1'b1
   } op_type;

   // One beat as it travels along the chain of cells. For a write, idx is the target
   // slot and data the colour; for a pixel, data is the pixel colour and idx, best_dist
   // and best_color track the best entry seen so far.
   typedef struct packed {
      logic                valid;
      op_type              op;
      logic [IDX_W-1:0]    idx;
      logic [COLOR_W-1:0]  data;
      logic [DIST_W-1:0]   best_dist;
      logic [COLOR_W-1:0]  best_color;
   } beat_type;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage
`default_nettype wire

[hdl/npc_cell.sv]
// One cell of the quantiser chain: holds one palette entry and updates the passing beat.
`timescale 1ns / 1ps
`default_nettype none
module npc_cell
   import npc_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire beat_type beat_i,
   output beat_type      beat_o
);

   localparam logic [IDX_W-1:0] CELL_ID = IDX_W'(CELL_INDEX);

   logic [COLOR_W-1:0] color_ff;
   beat_type           beat_ff;
   beat_type           beat_in;

   logic [CHAN_W-1:0]  diff_r;
   logic [CHAN_W-1:0]  diff_g;
   logic [CHAN_W-1:0]  diff_b;
   logic [DIST_W-1:0]  entry_dist;

   always_comb begin
      diff_r     = abs_diff(beat_i.data[RED_LSB +: CHAN_W],   color_ff[RED_LSB +: CHAN_W]);
      diff_g     = abs_diff(beat_i.data[GREEN_LSB +: CHAN_W], color_ff[GREEN_LSB +: CHAN_W]);
      diff_b     = abs_diff(beat_i.data[BLUE_LSB +: CHAN_W],  color_ff[BLUE_LSB +: CHAN_W]);
      entry_dist = DIST_W'(diff_r) + DIST_W'(diff_g) + DIST_W'(diff_b);
   end

   always_comb begin
      beat_in = beat_i;
      // Strictly smaller wins, so the lower index keeps a tie.
      if (beat_i.op == OP_PIXEL && entry_dist < beat_i.best_dist) begin
         beat_in.idx        = CELL_ID;
         beat_in.best_dist  = entry_dist;
         beat_in.best_color = color_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff.valid <= beat_in.valid;
      end
      if (advance) begin
         beat_ff.op         <= beat_in.op;
         beat_ff.idx        <= beat_in.idx;
         beat_ff.data       <= beat_in.data;
         beat_ff.best_dist  <= beat_in.best_dist;
         beat_ff.best_color <= beat_in.best_color;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && beat_i.valid && beat_i.op == OP_WRITE && beat_i.idx == CELL_ID) begin
         color_ff <= beat_i.data;
      end
   end

   assign beat_o = beat_ff;

`ifndef SYNTHESIS
   a_dist_bounded: assert property (@(posedge clock) disable iff (reset)
      beat_ff.valid && beat_ff.op == OP_PIXEL |-> beat_ff.best_dist <= DIST_LIMIT)
      else $error("pixel distance above the largest possible value");

   a_dist_falls: assert property (@(posedge clock) disable iff (reset)
      advance && beat_i.valid && beat_i.op == OP_PIXEL
      |=> beat_ff.best_dist <= $past(beat_i.best_dist))
      else $error("best distance grew while passing a cell");

   a_index_seen: assert property (@(posedge clock) disable iff (reset)
      beat_ff.valid && beat_ff.op == OP_PIXEL |-> beat_ff.idx <= CELL_ID)
      else $error("best index names a cell not yet passed");

   a_entry_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(color_ff))
      else $error("palette entry changed while the chain was held");
`endif

endmodule
`default_nettype wire

[hdl/nearest_palette_color_l1.sv]
// Top level of the nearest palette colour quantiser: a chain of palette cells.
//
// Usage: every beat on the req_ channel is either a palette write (req_operation low,
// req_entry_index and req_entry_color used) or a pixel (req_operation high, the three
// pixel channels used). A write gives no response; a pixel gives one rsp_ beat with the
// lowest palette index of least L1 colour distance and that entry's colour. Writes
// to slots at or above PALETTE_SIZE are dropped. All used slots must be loaded before
// pixels are sent.
// Every beat walks a chain of PALETTE_SIZE cells, one cell per cycle unless the chain
// is held; each cell holds one palette entry. The chain takes one beat per cycle while
// not held, so throughput is one pixel per clock; the output registers of all
// PALETTE_SIZE cells lie between acceptance and rsp_valid. Because writes travel down
// the same chain, a pixel sees exactly those writes accepted before it.
// Reset (synchronous, active high) empties the chain; palette contents are kept and
// are undefined until written. When the receiver stalls a pending response, the whole
// chain holds and req_stall is raised in the same cycle; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module nearest_palette_color_l1
   import npc_pkg::*;
#(
   parameter int PALETTE_SIZE = PALETTE_SIZE_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_operation,
   input  wire logic [IDX_W-1:0]   req_entry_index,
   input  wire logic [COLOR_W-1:0] req_entry_color,
   input  wire logic [CHAN_W-1:0]  req_pixel_red,
   input  wire logic [CHAN_W-1:0]  req_pixel_green,
   input  wire logic [CHAN_W-1:0]  req_pixel_blue,

   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [IDX_W-1:0]        rsp_nearest_index,
   output logic [CHAN_W-1:0]       rsp_quant_red,
   output logic [CHAN_W-1:0]       rsp_quant_green,
   output logic [CHAN_W-1:0]       rsp_quant_blue
);

   // chain[0] is the incoming beat; chain[k] is the output register of cell k-1.
   beat_type chain [PALETTE_SIZE+1];
   beat_type last_beat;
   logic     advance;

   // The final cell's register is the response register. A write reaching it is simply
   // dropped, so only a pending pixel response that is stalled holds the chain.
   assign last_beat = chain[PALETTE_SIZE];
   assign rsp_valid = last_beat.valid && last_beat.op == OP_PIXEL;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      chain[0].valid      = req_valid;
      chain[0].op         = op_type'(req_operation);
      chain[0].idx        = '0;
      chain[0].data       = {req_pixel_red, req_pixel_green, req_pixel_blue};
      chain[0].best_dist  = DIST_START;
      chain[0].best_color = '0;
      if (op_type'(req_operation) == OP_WRITE) begin
         chain[0].idx  = req_entry_index;
         chain[0].data = req_entry_color;
      end
   end

   for (genvar g = 0; g < PALETTE_SIZE; g++) begin : g_cell
      npc_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .beat_i  (chain[g]),
         .beat_o  (chain[g+1])
      );
   end

   assign rsp_nearest_index = last_beat.idx;
   assign rsp_quant_red     = last_beat.best_color[RED_LSB +: CHAN_W];
   assign rsp_quant_green   = last_beat.best_color[GREEN_LSB +: CHAN_W];
   assign rsp_quant_blue    = last_beat.best_color[BLUE_LSB +: CHAN_W];

endmodule
`default_nettype wire

[verif/nearest_palette_color_l1_test.sv]
// Self-checking testbench for the nearest palette colour quantiser.
`timescale 1ns / 1ps
module nearest_palette_color_l1_test;
   import npc_pkg::*;

   localparam int PALETTE_ENTRIES = PALETTE_SIZE_DEFAULT;
   // Every beat walks one cell per cycle while the chain is not held, so the chain length sets the latency.
   localparam int CHAIN_LATENCY   = PALETTE_SIZE_DEFAULT;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      logic [IDX_W-1:0]  nearest_index;
      logic [CHAN_W-1:0] quant_red;
      logic [CHAN_W-1:0] quant_green;
      logic [CHAN_W-1:0] quant_blue;
   } quant_result_type;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   op_type             req_operation   = OP_WRITE;
   logic [IDX_W-1:0]   req_entry_index = '0;
   logic [COLOR_W-1:0] req_entry_color = '0;
   logic [CHAN_W-1:0]  req_pixel_red   = '0;
   logic [CHAN_W-1:0]  req_pixel_green = '0;
   logic [CHAN_W-1:0]  req_pixel_blue  = '0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic [IDX_W-1:0]   rsp_nearest_index;
   logic [CHAN_W-1:0]  rsp_quant_red;
   logic [CHAN_W-1:0]  rsp_quant_green;
   logic [CHAN_W-1:0]  rsp_quant_blue;

   // Shadow copy of the palette, updated in the order that beats are accepted.
   logic [COLOR_W-1:0] palette_shadow [PALETTE_ENTRIES];
   quant_result_type   expected_quant [$];

   logic [COLOR_W-1:0] basic_colors [16] = '{
      24'h000000, 24'h800000, 24'h008000, 24'h808000,
      24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0,
      24'h808080, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
      24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF};
   logic [CHAN_W-1:0]  cube_levels [6] = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};

   int error_count        = 0;
   int cycle_count        = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_off_request   = 0;
   int hold_left          = 0;

   always #2 clock = ~clock;

   nearest_palette_color_l1 uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_entry_index   (req_entry_index),
      .req_entry_color   (req_entry_color),
      .req_pixel_red     (req_pixel_red),
      .req_pixel_green   (req_pixel_green),
      .req_pixel_blue    (req_pixel_blue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_quant_red     (rsp_quant_red),
      .rsp_quant_green   (rsp_quant_green),
      .rsp_quant_blue    (rsp_quant_blue)
   );

   function automatic logic [DIST_W-1:0] channel_gap(input logic [CHAN_W-1:0] a,
                                                     input logic [CHAN_W-1:0] b);
      channel_gap = (a > b) ? DIST_W'(a - b) : DIST_W'(b - a);
   endfunction

   // Scans the shadow palette; only a strictly smaller distance moves the choice,
   // so the lowest index wins among equals.
   function automatic quant_result_type nearest_entry(input logic [CHAN_W-1:0] r,
                                                      input logic [CHAN_W-1:0] g,
                                                      input logic [CHAN_W-1:0] b);
      quant_result_type   res;
      logic [DIST_W-1:0]  best_dist;
      logic [DIST_W-1:0]  gap_sum;
      logic [COLOR_W-1:0] c;
      res       = '0;
      best_dist = DIST_START;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         c       = palette_shadow[i];
         gap_sum = channel_gap(r, c[RED_LSB +: CHAN_W]) + channel_gap(g, c[GREEN_LSB +: CHAN_W])
                   + channel_gap(b, c[BLUE_LSB +: CHAN_W]);
         if (gap_sum < best_dist) begin
            best_dist         = gap_sum;
            res.nearest_index = IDX_W'(i);
         end
      end
      c               = palette_shadow[res.nearest_index];
      res.quant_red   = c[RED_LSB +: CHAN_W];
      res.quant_green = c[GREEN_LSB +: CHAN_W];
      res.quant_blue  = c[BLUE_LSB +: CHAN_W];
      return res;
   endfunction

   // A channel value a few steps away from the given one, kept within range.
   function automatic logic [CHAN_W-1:0] near_channel(input logic [CHAN_W-1:0] c);
      int v;
      v = int'(c) + int'($urandom_range(6)) - 3;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return CHAN_W'(v);
   endfunction

   task automatic note_failure(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
   endtask

   // Offers one beat, with random idle cycles in front of it, and holds it until
   // accepted; the prediction is made at the edge where it is taken.
   task automatic send_item(input op_type op, input logic [IDX_W-1:0] idx,
                            input logic [COLOR_W-1:0] color, input logic [CHAN_W-1:0] r,
                            input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid       <= 1'b0;
         req_operation   <= op_type'($urandom_range(1));
         req_entry_index <= IDX_W'($urandom);
         req_entry_color <= COLOR_W'($urandom);
         req_pixel_red   <= CHAN_W'($urandom);
         req_pixel_green <= CHAN_W'($urandom);
         req_pixel_blue  <= CHAN_W'($urandom);
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_entry_index <= idx;
      req_entry_color <= color;
      req_pixel_red   <= r;
      req_pixel_green <= g;
      req_pixel_blue  <= b;
      do @(posedge clock); while (req_stall);
      if (op == OP_WRITE) begin
         if (int'(idx) < PALETTE_ENTRIES) palette_shadow[idx] = color;
      end else begin
         expected_quant.push_back(nearest_entry(r, g, b));
      end
   endtask

   task automatic send_write(input logic [IDX_W-1:0] slot, input logic [COLOR_W-1:0] color);
      send_item(OP_WRITE, slot, color, CHAN_W'($urandom), CHAN_W'($urandom),
                CHAN_W'($urandom));
   endtask

   task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b);
      send_item(OP_PIXEL, IDX_W'($urandom), COLOR_W'($urandom), r, g, b);
   endtask

   // Loads every slot: sixteen basic colours, a six-level colour cube and a grey ramp.
   // The table repeats black, white and the primaries, which gives ties at once.
   task automatic test_load_palette();
      logic [COLOR_W-1:0] color;
      logic [CHAN_W-1:0]  grey;
      int                 k;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         if (i < 16) begin
            color = basic_colors[i];
         end else if (i < 232) begin
            k     = i - 16;
            color = {cube_levels[k / 36], cube_levels[(k / 6) % 6], cube_levels[k % 6]};
         end else begin
            grey  = CHAN_W'(8 + 10 * (i - 232));
            color = {grey, grey, grey};
         end
         send_write(IDX_W'(i), color);
      end
   endtask

   task automatic test_extreme_pixels();
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h00, 8'hFF, 8'h00);
      send_pixel(8'h00, 8'h00, 8'hFF);
      send_pixel(8'hFF, 8'h00, 8'hFF);
      // Halfway between two greys of the ramp: equal distance, lower slot expected.
      send_pixel(8'd13, 8'd13, 8'd13);
      send_pixel(8'h80, 8'h80, 8'h80);
      send_pixel(8'hFF, 8'hFF, 8'hFE);
   endtask

   // A pixel must see a write accepted just in front of it, and duplicates must
   // resolve to the lower slot.
   task automatic test_write_order_and_ties();
      send_write(8'd255, 24'h123456);
      send_pixel(8'h12, 8'h34, 8'h56);
      send_write(8'd3, 24'h123456);
      send_pixel(8'h12, 8'h34, 8'h56);
      send_write(8'd0, 24'hFFFFFF);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_write(8'd0, 24'h000000);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_write(8'd3, 24'h808000);
      send_pixel(8'h13, 8'h33, 8'h57);
   endtask

   // Mostly pixels, just under half of them close to a palette colour so that near ties occur;
   // writes either take a fresh colour or copy another slot's colour.
   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct);
      int                 pick;
      logic [COLOR_W-1:0] c;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) begin
         pick = $urandom_range(99);
         c    = palette_shadow[$urandom_range(PALETTE_ENTRIES - 1)];
         if (pick < 15) begin
            send_write(IDX_W'($urandom), COLOR_W'($urandom));
         end else if (pick < 25) begin
            send_write(IDX_W'($urandom), c);
         end else if (pick < 60) begin
            send_pixel(near_channel(c[RED_LSB +: CHAN_W]), near_channel(c[GREEN_LSB +: CHAN_W]),
                       near_channel(c[BLUE_LSB +: CHAN_W]));
         end else begin
            send_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
         end
      end
   endtask

   // The receiver holds off well beyond the chain length while pixels keep coming,
   // so the oldest pixel waits at the end of the chain and the block has to stall
   // its input for a long stretch.
   task automatic test_back_pressure();
      sender_idle_pct    = 83;
      receiver_stall_pct = 0;
      hold_off_request   = 3 * CHAIN_LATENCY;
      repeat (100) begin
         send_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
      end
   endtask

   // Receiver: random stall, or a long counted hold-off when one is asked for.
   always @(negedge clock) begin
      if (hold_off_request > 0) begin
         hold_left        = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Compares each accepted result beat with the oldest prediction.
   always @(posedge clock) begin
      quant_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_quant.size() == 0) begin
            note_failure($sformatf("result with none expected: index %0d colour %h%h%h",
                                   rsp_nearest_index, rsp_quant_red, rsp_quant_green,
                                   rsp_quant_blue));
         end else begin
            want = expected_quant.pop_front();
            if (rsp_nearest_index !== want.nearest_index || rsp_quant_red !== want.quant_red
                || rsp_quant_green !== want.quant_green || rsp_quant_blue !== want.quant_blue)
            begin
               note_failure($sformatf("expected index %0d rgb %h %h %h, got index %0d rgb %h %h %h",
                                      want.nearest_index, want.quant_red, want.quant_green,
                                      want.quant_blue, rsp_nearest_index, rsp_quant_red,
                                      rsp_quant_green, rsp_quant_blue));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[nearest_palette_color_l1] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_load_palette();
      test_extreme_pixels();
      test_write_order_and_ties();
      test_random_traffic(40, 0, 0);
      test_random_traffic(40, 83, 0);
      test_random_traffic(40, 0, 83);
      test_random_traffic(40, 13, 13);
      test_back_pressure();

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_quant.size() != 0) @(posedge clock);
      repeat (CHAIN_LATENCY + 16) @(posedge clock);

      if (error_count == 0) begin
         $display("[nearest_palette_color_l1] OK");
      end else begin
         $display("[nearest_palette_color_l1] ERROR");
      end
      $finish;
   end

endmodule
